/* rtl/edp_pkg.sv */
`timescale 1ns / 1ps

package edp_pkg;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int LEVEL_W = 8;
    localparam int ADDR_W  = 3;
    localparam int CFG_W   = 16;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_EDGE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPI    = 2'd3;

    localparam logic [BYTE_W-1:0] SPI_RESET_CMD = 8'h01;
    localparam logic [BYTE_W-1:0] SPI_READ_CMD  = 8'h03;

    localparam logic [ADDR_W-1:0] REG_LEVEL_STEP    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_CUT_OFF_BELOW = 3'd1;
    localparam logic [ADDR_W-1:0] REG_CLAMP_ABOVE   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_INITIAL_LEVEL = 3'd3;
    localparam logic [ADDR_W-1:0] REG_COUNT_CENTER  = 3'd4;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 8'd255;

    localparam logic [LEVEL_W-1:0] STEP_RST   = 8'd25;
    localparam logic [LEVEL_W-1:0] CUT_RST    = 8'd30;
    localparam logic [LEVEL_W-1:0] CLAMP_RST  = 8'd225;
    localparam logic [LEVEL_W-1:0] LEVEL_RST  = 8'd127;
    localparam logic [COUNT_W-1:0] CENTER_RST = 16'h7FFF;

endpackage

/* rtl/encoder_dimmer_with_count_readout.sv */
`timescale 1ns / 1ps

// Rotary encoder dimmer with count readout. Each input beat is one event:
// an encoder edge, a control-loop tick or an SPI command byte, and each
// produces exactly one output beat. One beat is accepted per clock unless
// the output stalls; each beat passes an input register, then a result
// register. The rate is set by the state update in the processing stage,
// which resolves the count compare, level step, ramp and button toggle of a
// tick in one pass. The user must write registers through the cfg port only
// while the block is idle; the block itself does not enforce this. Writes
// to initial_level are ignored; reset restores each register's default.
module encoder_dimmer_with_count_readout
    import edp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_wr_en,
    input  logic [ADDR_W-1:0]     i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] other_phase, [1] button_level, [9:2] spi_byte, zero padded
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [CMD_W-1:0]      s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] count_value, [23:16] duty, [24] pwm_on, [25] dir_level,
    // [26] count_pulse, zero padded
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] read_valid
    output logic                  m_axis_tuser
);

    // configuration
    logic [LEVEL_W-1:0] r_step;
    logic [LEVEL_W-1:0] r_cut;
    logic [LEVEL_W-1:0] r_clamp;
    logic [COUNT_W-1:0] r_center;

    // input stage
    logic               r_in_vld;
    logic [CMD_W-1:0]   r_in_cmd;
    logic               r_in_other;
    logic               r_in_button;
    logic [BYTE_W-1:0]  r_in_spi;

    // state
    logic [COUNT_W-1:0] r_count,  n_count;
    logic               r_armed,  n_armed;
    logic [COUNT_W-1:0] r_last,   n_last;
    logic [LEVEL_W-1:0] r_target, n_target;
    logic [LEVEL_W-1:0] r_ramp,   n_ramp;
    logic [LEVEL_W-1:0] r_saved,  n_saved;
    logic               r_press,  n_press;
    logic               r_en,     n_en;
    logic               r_dir,    n_dir;

    // result stage
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_read;

    logic                  w_adv;
    logic                  w_fire;
    logic                  w_pulse;
    logic                  w_read;
    logic [LEVEL_W-1:0]    w_tgt;
    logic [LEVEL_W:0]      w_up_sum;

    assign w_adv         = !r_out_vld || m_axis_tready;
    assign w_fire        = r_in_vld && w_adv;
    assign s_axis_tready = !r_in_vld || w_adv;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_RST;
            r_cut    <= CUT_RST;
            r_clamp  <= CLAMP_RST;
            r_center <= CENTER_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_LEVEL_STEP:    r_step   <= i_cfg_wdata[LEVEL_W-1:0];
                REG_CUT_OFF_BELOW: r_cut    <= i_cfg_wdata[LEVEL_W-1:0];
                REG_CLAMP_ABOVE:   r_clamp  <= i_cfg_wdata[LEVEL_W-1:0];
                // initial_level writes are ignored; reset loads the LEVEL_RST default
                REG_INITIAL_LEVEL: ;
                REG_COUNT_CENTER:  r_center <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_count  = r_count;
        n_armed  = r_armed;
        n_last   = r_last;
        n_target = r_target;
        n_ramp   = r_ramp;
        n_saved  = r_saved;
        n_press  = r_press;
        n_en     = r_en;
        n_dir    = r_dir;
        w_pulse  = 1'b0;
        w_read   = 1'b0;
        w_tgt    = r_target;
        w_up_sum = {1'b0, r_target} + {1'b0, r_step};

        unique case (r_in_cmd) inside
            CMD_EDGE_A, CMD_EDGE_B: begin
                if (r_armed && !r_in_other) begin
                    n_armed = 1'b0;
                    if (r_in_cmd == CMD_EDGE_B) begin
                        n_count = r_count + COUNT_W'(1);
                    end else begin
                        n_count = r_count - COUNT_W'(1);
                    end
                end else begin
                    n_armed = 1'b1;
                end
            end
            CMD_TICK: begin
                if (r_last > r_count) begin
                    n_dir   = 1'b0;
                    w_pulse = 1'b1;
                    n_last  = r_count;
                    if (r_target < r_cut) begin
                        w_tgt = '0;
                        n_en  = 1'b0;
                    end else if (r_target < r_step) begin
                        w_tgt = '0;
                    end else begin
                        w_tgt = r_target - r_step;
                    end
                end else if (r_last < r_count) begin
                    n_dir   = 1'b1;
                    w_pulse = 1'b1;
                    n_last  = r_count;
                    if (r_target > r_clamp) begin
                        w_tgt = FULL_SCALE;
                    end else begin
                        n_en  = 1'b1;
                        w_tgt = w_up_sum[LEVEL_W] ? FULL_SCALE : w_up_sum[LEVEL_W-1:0];
                    end
                end

                if (r_ramp < w_tgt) begin
                    if (r_ramp == '0) begin
                        n_en = 1'b1;
                    end
                    n_ramp = r_ramp + LEVEL_W'(1);
                end else if (r_ramp > w_tgt) begin
                    n_ramp = r_ramp - LEVEL_W'(1);
                    if (r_ramp == LEVEL_W'(1)) begin
                        n_en = 1'b0;
                    end
                end

                n_target = w_tgt;
                if (!r_in_button) begin
                    n_press = 1'b1;
                end else if (r_press) begin
                    if (w_tgt != '0) begin
                        n_saved  = w_tgt;
                        n_target = '0;
                    end else begin
                        n_target = r_saved;
                    end
                    n_press = 1'b0;
                end
            end
            CMD_SPI: begin
                if (r_in_spi == SPI_RESET_CMD) begin
                    n_count = r_center;
                end else if (r_in_spi == SPI_READ_CMD) begin
                    w_read = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_count   <= CENTER_RST;
            r_armed   <= 1'b0;
            r_last    <= CENTER_RST;
            r_target  <= LEVEL_RST;
            r_ramp    <= LEVEL_RST;
            r_saved   <= LEVEL_RST;
            r_press   <= 1'b0;
            r_en      <= 1'b1;
            r_dir     <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
            if (w_fire) begin
                r_count  <= n_count;
                r_armed  <= n_armed;
                r_last   <= n_last;
                r_target <= n_target;
                r_ramp   <= n_ramp;
                r_saved  <= n_saved;
                r_press  <= n_press;
                r_en     <= n_en;
                r_dir    <= n_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd    <= s_axis_tuser;
            r_in_other  <= s_axis_tdata[0];
            r_in_button <= s_axis_tdata[1];
            r_in_spi    <= s_axis_tdata[9:2];
        end
        if (w_fire) begin
            r_out_data <= {5'd0, w_pulse, n_dir, n_en, n_ramp, n_count};
            r_out_read <= w_read;
        end
    end

    a_ramp_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_cmd != CMD_TICK) |=> $stable(r_ramp))
        else $error("ramp level moved on a non-tick beat");

    a_ramp_unit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_ramp == $past(r_ramp) ||
                    r_ramp == LEVEL_W'($past(r_ramp) + LEVEL_W'(1)) ||
                    r_ramp == LEVEL_W'($past(r_ramp) - LEVEL_W'(1))))
        else $error("ramp level moved by more than one");

    a_last_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_cmd != CMD_TICK) |=> $stable(r_last))
        else $error("last seen count changed outside a tick");

    a_read_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_read) |-> !r_out_data[26])
        else $error("read beat carries a count pulse");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import edp_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               rd;
        logic [LEVEL_W-1:0] duty;
        logic               pwm;
        logic               dir;
        logic               pulse;
    } t_dimmer_out;

    class t_dimmer_scoreboard;
        logic [LEVEL_W-1:0] step_r;
        logic [LEVEL_W-1:0] cut_r;
        logic [LEVEL_W-1:0] clamp_r;
        logic [LEVEL_W-1:0] init_r;
        logic [COUNT_W-1:0] center_r;

        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] last_seen;
        logic               armed;
        logic [LEVEL_W-1:0] target;
        logic [LEVEL_W-1:0] ramp;
        logic [LEVEL_W-1:0] saved;
        logic               press;
        logic               enabled;
        logic               dir;

        t_dimmer_out expected_q[$];
        int errors;

        function new();
            errors = 0;
            step_r   = STEP_RST;
            cut_r    = CUT_RST;
            clamp_r  = CLAMP_RST;
            init_r   = LEVEL_RST;
            center_r = CENTER_RST;
            count     = center_r;
            last_seen = center_r;
            armed     = 1'b0;
            target    = init_r;
            ramp      = init_r;
            saved     = init_r;
            press     = 1'b0;
            enabled   = 1'b1;
            dir       = 1'b0;
        endfunction

        // initial_level only matters at reset, which happens once
        function void write_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
            case (addr)
                REG_LEVEL_STEP:    step_r   = data[LEVEL_W-1:0];
                REG_CUT_OFF_BELOW: cut_r    = data[LEVEL_W-1:0];
                REG_CLAMP_ABOVE:   clamp_r  = data[LEVEL_W-1:0];
                REG_INITIAL_LEVEL: init_r   = data[LEVEL_W-1:0];
                REG_COUNT_CENTER:  center_r = data;
                default: ;
            endcase
        endfunction

        function void encoder_edge(logic other, logic up);
            if (armed && !other) begin
                armed = 1'b0;
                count = up ? count + 16'd1 : count - 16'd1;
            end else begin
                armed = 1'b1;
            end
        endfunction

        function logic control_tick(logic button);
            logic       pulse;
            logic [8:0] sum;
            pulse = 1'b0;
            if (last_seen > count) begin
                dir   = 1'b0;
                pulse = 1'b1;
                if (target < cut_r) begin
                    target  = '0;
                    enabled = 1'b0;
                end else if (target < step_r) begin
                    target = '0;
                end else begin
                    target = target - step_r;
                end
                last_seen = count;
            end
            if (last_seen < count) begin
                dir   = 1'b1;
                pulse = 1'b1;
                if (target > clamp_r) begin
                    target = FULL_SCALE;
                end else begin
                    enabled = 1'b1;
                    sum = {1'b0, target} + {1'b0, step_r};
                    target = (sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : sum[7:0];
                end
                last_seen = count;
            end
            // duty ramps one step per tick
            if (ramp < target) begin
                if (ramp == '0) enabled = 1'b1;
                ramp = ramp + 8'd1;
            end
            if (ramp > target) begin
                ramp = ramp - 8'd1;
                if (ramp == '0) enabled = 1'b0;
            end
            // toggle on release
            if (!button) press = 1'b1;
            if (button && press) begin
                if (target > '0) begin
                    saved  = target;
                    target = '0;
                end else begin
                    target = saved;
                end
                press = 1'b0;
            end
            return pulse;
        endfunction

        function void note_input(logic [CMD_W-1:0] cmd, logic other, logic button,
                                 logic [BYTE_W-1:0] spi);
            t_dimmer_out e;
            e = '0;
            case (cmd)
                CMD_EDGE_A: encoder_edge(other, 1'b0);
                CMD_EDGE_B: encoder_edge(other, 1'b1);
                CMD_TICK:   e.pulse = control_tick(button);
                default: begin
                    if (spi == SPI_RESET_CMD) count = center_r;
                    else if (spi == SPI_READ_CMD) e.rd = 1'b1;
                end
            endcase
            e.count = count;
            e.duty  = ramp;
            e.pwm   = enabled;
            e.dir   = dir;
            expected_q.push_back(e);
        endfunction

        function void compare(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic rd);
            t_dimmer_out e;
            if (expected_q.size() == 0) begin
                $error("output beat with nothing pending");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare("count_value", e.count, data[15:0]);
            compare("read_valid", e.rd, rd);
            compare("duty", e.duty, data[23:16]);
            compare("pwm_on", e.pwm, data[24]);
            compare("dir_level", e.dir, data[25]);
            compare("count_pulse", e.pulse, data[26]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [ADDR_W-1:0]     i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    t_dimmer_scoreboard sb;
    int   beats_sent;
    logic src_quiet;
    logic sink_quiet;
    logic turn_up;

    encoder_dimmer_with_count_readout u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        sb.write_reg(addr, data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_event(logic [CMD_W-1:0] cmd, logic other, logic button,
                              logic [BYTE_W-1:0] spi);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 29) == 0) src_quiet = !src_quiet;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, spi, button, other};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(cmd, other, button, spi);
        beats_sent++;
    endtask

    // wait for the pipe to empty before touching registers
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_event();
        int r;
        logic [CMD_W-1:0] ecmd;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            // one detent: edges in the same direction, meant to arm and then count
            if ($urandom_range(0, 15) == 0) turn_up = !turn_up;
            ecmd = turn_up ? CMD_EDGE_B : CMD_EDGE_A;
            send_event(ecmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)));
            send_event(ecmd, $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)));
        end else if (r < 80) begin
            send_event(CMD_TICK, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                       8'($urandom_range(0, 255)));
        end else if (r < 87) begin
            send_event(CMD_SPI, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       SPI_READ_CMD);
        end else if (r < 91) begin
            send_event(CMD_SPI, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       SPI_RESET_CMD);
        end else if (r < 96) begin
            send_event(CMD_SPI, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)));
        end else begin
            ecmd = $urandom_range(0, 1) ? CMD_EDGE_B : CMD_EDGE_A;
            send_event(ecmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)));
        end
    endtask

    task automatic apply_setting(int p);
        logic [LEVEL_W-1:0] step_v;
        logic [LEVEL_W-1:0] cut_v;
        logic [LEVEL_W-1:0] clamp_v;
        logic [LEVEL_W-1:0] init_v;
        logic [COUNT_W-1:0] center_v;
        step_v   = LEVEL_W'($urandom_range(1, 255));
        cut_v    = LEVEL_W'($urandom_range(0, 255));
        clamp_v  = LEVEL_W'($urandom_range(0, 255));
        init_v   = LEVEL_W'($urandom_range(0, 255));
        center_v = COUNT_W'($urandom_range(0, 65535));
        case (p)
            0: begin
                step_v = STEP_RST; cut_v = CUT_RST; clamp_v = CLAMP_RST;
                init_v = 8'd0; center_v = CENTER_RST;
            end
            1: begin
                step_v = 8'd1; cut_v = 8'd0; clamp_v = 8'd255;
                init_v = 8'd255; center_v = 16'h0000;
            end
            2: begin
                step_v = 8'd255; cut_v = 8'd0; clamp_v = 8'd0;
                init_v = 8'd0; center_v = 16'hFFFF;
            end
            3: begin
                step_v = 8'd200; cut_v = 8'd255; clamp_v = 8'd128;
            end
            default: ;
        endcase
        cfg_write(REG_LEVEL_STEP, {8'd0, step_v});
        cfg_write(REG_CUT_OFF_BELOW, {8'd0, cut_v});
        cfg_write(REG_CLAMP_ABOVE, {8'd0, clamp_v});
        cfg_write(REG_INITIAL_LEVEL, {8'd0, init_v});
        cfg_write(REG_COUNT_CENTER, center_v);
    endtask

    initial begin
        m_axis_tready = 1'b0;
        sink_quiet    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int gap;
            gap = sink_quiet ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 29) == 0) sink_quiet = !sink_quiet;
            @(negedge i_clk);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        int goal;
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_EDGE_A;
        beats_sent    = 0;
        src_quiet     = 1'b0;
        turn_up       = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: SPI bytes, arm logic, both step directions, button toggle
        send_event(CMD_SPI, 1'b0, 1'b0, SPI_READ_CMD);
        send_event(CMD_SPI, 1'b1, 1'b1, 8'h00);
        send_event(CMD_SPI, 1'b0, 1'b1, 8'hFF);
        send_event(CMD_SPI, 1'b1, 1'b0, 8'h02);
        send_event(CMD_EDGE_A, 1'b1, 1'b0, 8'h00);
        send_event(CMD_EDGE_A, 1'b0, 1'b0, 8'h00);
        send_event(CMD_TICK, 1'b0, 1'b1, 8'h00);
        send_event(CMD_EDGE_B, 1'b0, 1'b0, 8'h00);
        send_event(CMD_EDGE_B, 1'b1, 1'b0, 8'h00);
        send_event(CMD_EDGE_B, 1'b0, 1'b0, 8'h00);
        send_event(CMD_EDGE_B, 1'b1, 1'b0, 8'h00);
        send_event(CMD_EDGE_B, 1'b0, 1'b0, 8'h00);
        send_event(CMD_TICK, 1'b1, 1'b1, 8'hFF);
        send_event(CMD_TICK, 1'b0, 1'b0, 8'h00);
        send_event(CMD_TICK, 1'b0, 1'b1, 8'h00);
        send_event(CMD_TICK, 1'b0, 1'b1, 8'h00);
        send_event(CMD_TICK, 1'b0, 1'b0, 8'h00);
        send_event(CMD_TICK, 1'b0, 1'b1, 8'h00);
        send_event(CMD_SPI, 1'b0, 1'b0, SPI_RESET_CMD);
        send_event(CMD_TICK, 1'b0, 1'b1, 8'h00);
        send_event(CMD_SPI, 1'b0, 1'b0, SPI_READ_CMD);
        send_event(CMD_TICK, 1'b1, 1'b0, 8'hAA);
        send_event(CMD_TICK, 1'b0, 1'b1, 8'h55);
        drain();

        for (int p = 0; p < 5; p++) begin
            apply_setting(p);
            goal = beats_sent + 335;
            while (beats_sent < goal) random_event();
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
